### rtl/core/rtp_retransmit_buffer_macros.svh
// assertion macros shared by the retransmit buffer rtl
`ifndef RTP_RETRANSMIT_BUFFER_MACROS_SVH
`define RTP_RETRANSMIT_BUFFER_MACROS_SVH

// property checked on every rising edge outside reset
`define RTPB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RTPB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/rtpb_pkg.sv
// types and constants of the rtp retransmit buffer
package rtpb_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned RTX_W   = 8;
  localparam int unsigned SUM_W   = 24;

  localparam logic [CFG_W-1:0] CLEAN_INTERVAL_RST = 24'd1000000;
  localparam logic [CFG_W-1:0] MAX_AGE_RST        = 24'd1000000;

  typedef enum logic [1:0] {
    REQ_SENT = 2'd0,
    REQ_NACK = 2'd1,
    REQ_TICK = 2'd2,
    REQ_POP  = 2'd3
  } req_e;

  typedef enum logic {
    CFG_CLEAN_INTERVAL = 1'b0,
    CFG_MAX_AGE        = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SEQ_W-1:0]   seq_num;
    logic [BYTES_W-1:0] pkt_bytes;
    logic               is_padding;
    logic [TIME_W-1:0]  now_us;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [SEQ_W-1:0]   out_seq;
    logic [BYTES_W-1:0] out_bytes;
    logic [RTX_W-1:0]   out_rtx_count;
    logic [BYTES_W-1:0] next_bytes;
    logic [SUM_W-1:0]   pending_bytes;
    logic               overwrote;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic               pending;
    logic [SEQ_W-1:0]   seq;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  sent_time;
    logic [RTX_W-1:0]   count;
  } entry_t;

endpackage

### rtl/core/rtpb_mem.sv
// record table: one write port, one read port, registered read data
module rtpb_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 106
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/rtp_retransmit_buffer.sv
// rtp retransmit buffer: sent packet records with nack, pop and aging
//
// Each transaction takes one pass over the whole record table: after reset a
// clearing pass writes every entry before the first transaction is taken,
// then every transaction does a read-modify-write on one entry where the
// request needs one, a scan through the single read port of the table, and
// a final step that loads the result.
// The scan ages out old records on a sweep and finds the lowest pending
// sequence number and the pending byte total. TABLE_DEPTH must be a power of
// two; records are placed by the low bits of the sequence number.
`include "rtp_retransmit_buffer_macros.svh"

module rtp_retransmit_buffer #(
  parameter int unsigned TABLE_DEPTH = rtpb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rtpb_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rtpb_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rtpb_pkg::rsp_t             out_data_o
);
  import rtpb_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam int unsigned ENT_W = $bits(entry_t);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic   sweep_q, sweep_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic   rv_q, rv_d;
  logic [IDX_W-1:0] rv_idx_q, rv_idx_d;
  logic   acc_found_q, acc_found_d;
  logic [SEQ_W-1:0] acc_seq_q, acc_seq_d;
  logic [BYTES_W-1:0] acc_bytes_q, acc_bytes_d;
  logic [IDX_W-1:0] acc_idx_q, acc_idx_d;
  logic [SUM_W-1:0] acc_sum_q, acc_sum_d;
  logic   low_valid_q, low_valid_d;
  logic [IDX_W-1:0] low_idx_q, low_idx_d;
  logic [SUM_W-1:0] pend_sum_q, pend_sum_d;
  logic [TIME_W-1:0] last_sweep_q, last_sweep_d;
  logic [CFG_W-1:0] clean_int_q, max_age_q;
  logic   res_found_q, res_found_d;
  logic [SEQ_W-1:0] res_seq_q, res_seq_d;
  logic [BYTES_W-1:0] res_bytes_q, res_bytes_d;
  logic [RTX_W-1:0] res_cnt_q, res_cnt_d;
  logic   res_over_q, res_over_d;
  logic   out_valid_q, out_valid_d;
  rsp_t   out_q, out_d;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  logic [ENT_W-1:0] mem_rdata_raw;

  logic             start_scan;
  logic [IDX_W-1:0] slot;
  entry_t           ent;
  logic [TIME_W-1:0] age;
  logic [SUM_W:0]   sum_ext;
  req_e             req_type;

  assign slot       = req_q.seq_num[IDX_W-1:0];
  assign req_type   = req_e'(req_q.req_type);
  assign mem_rdata  = entry_t'(mem_rdata_raw);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  rtpb_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ENT_W'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata_raw)
  );

  // next state, table accesses and accumulation
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    sweep_d      = sweep_q;
    cnt_d        = cnt_q;
    rv_d         = 1'b0;
    rv_idx_d     = rv_idx_q;
    acc_found_d  = acc_found_q;
    acc_seq_d    = acc_seq_q;
    acc_bytes_d  = acc_bytes_q;
    acc_idx_d    = acc_idx_q;
    acc_sum_d    = acc_sum_q;
    low_valid_d  = low_valid_q;
    low_idx_d    = low_idx_q;
    pend_sum_d   = pend_sum_q;
    last_sweep_d = last_sweep_q;
    res_found_d  = res_found_q;
    res_seq_d    = res_seq_q;
    res_bytes_d  = res_bytes_q;
    res_cnt_d    = res_cnt_q;
    res_over_d   = res_over_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = slot;
    start_scan   = 1'b0;
    ent          = mem_rdata;
    age          = '0;
    sum_ext      = '0;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == DEPTH_C - 1'b1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_data_i;
          sweep_d     = 1'b0;
          res_found_d = 1'b0;
          res_seq_d   = '0;
          res_bytes_d = '0;
          res_cnt_d   = '0;
          res_over_d  = 1'b0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        unique case (req_type)
          REQ_TICK: begin
            sweep_d = (req_q.now_us - last_sweep_q) >= TIME_W'(clean_int_q);
            if (sweep_d) begin
              last_sweep_d = req_q.now_us;
            end
            start_scan = 1'b1;
          end
          REQ_POP: begin
            if (low_valid_q) begin
              mem_re    = 1'b1;
              mem_raddr = low_idx_q;
              state_d   = ST_MODIFY;
            end else begin
              start_scan = 1'b1;
            end
          end
          REQ_SENT: begin
            if (req_q.is_padding) begin
              start_scan = 1'b1;
            end else begin
              mem_re  = 1'b1;
              state_d = ST_MODIFY;
            end
          end
          REQ_NACK: begin
            mem_re  = 1'b1;
            state_d = ST_MODIFY;
          end
          default: start_scan = 1'b1;
        endcase
      end
      ST_MODIFY: begin
        mem_we     = 1'b1;
        start_scan = 1'b1;
        unique case (req_type)
          REQ_SENT: begin
            if (ent.valid && ent.seq == req_q.seq_num) begin
              if (ent.count != '1) begin
                ent.count = ent.count + 1'b1;
              end
            end else begin
              res_over_d  = ent.valid;
              ent.valid   = 1'b1;
              ent.pending = 1'b0;
              ent.seq     = req_q.seq_num;
              ent.count   = '0;
            end
            ent.bytes     = req_q.pkt_bytes;
            ent.sent_time = req_q.now_us;
          end
          REQ_NACK: begin
            if (ent.valid && ent.seq == req_q.seq_num) begin
              ent.pending = 1'b1;
              res_found_d = 1'b1;
            end
          end
          REQ_POP: begin
            mem_waddr   = low_idx_q;
            ent.pending = 1'b0;
            res_found_d = 1'b1;
            res_seq_d   = ent.seq;
            res_bytes_d = ent.bytes;
            res_cnt_d   = ent.count;
          end
          default: mem_we = 1'b0;
        endcase
        mem_wdata = ent;
      end
      ST_SCAN: begin
        // issue the next read of the pass
        if (cnt_q < DEPTH_C) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
          rv_d      = 1'b1;
          rv_idx_d  = cnt_q[IDX_W-1:0];
        end
        // age out and accumulate the entry that came back
        if (rv_q) begin
          age = req_q.now_us - ent.sent_time;
          if (sweep_q && ent.valid && (age > TIME_W'(max_age_q))) begin
            ent.valid   = 1'b0;
            ent.pending = 1'b0;
            mem_we      = 1'b1;
            mem_waddr   = rv_idx_q;
            mem_wdata   = ent;
          end
          if (ent.valid && ent.pending) begin
            if (!acc_found_q || (ent.seq < acc_seq_q)) begin
              acc_found_d = 1'b1;
              acc_seq_d   = ent.seq;
              acc_bytes_d = ent.bytes;
              acc_idx_d   = rv_idx_q;
            end
            sum_ext = {1'b0, acc_sum_q} + (SUM_W + 1)'(ent.bytes);
            acc_sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          end
          if (cnt_q == DEPTH_C) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.found         = res_found_q;
          out_d.out_seq       = res_seq_q;
          out_d.out_bytes     = res_bytes_q;
          out_d.out_rtx_count = res_cnt_q;
          out_d.next_bytes    = acc_found_q ? acc_bytes_q : '0;
          out_d.pending_bytes = acc_sum_q;
          out_d.overwrote     = res_over_q;
          low_valid_d         = acc_found_q;
          low_idx_d           = acc_idx_q;
          pend_sum_d          = acc_sum_q;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // begin a pass over the table
    if (start_scan) begin
      cnt_d       = '0;
      acc_found_d = 1'b0;
      acc_sum_d   = '0;
      state_d     = ST_SCAN;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      rv_q         <= 1'b0;
      low_valid_q  <= 1'b0;
      pend_sum_q   <= '0;
      last_sweep_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rv_q         <= rv_d;
      low_valid_q  <= low_valid_d;
      pend_sum_q   <= pend_sum_d;
      last_sweep_q <= last_sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_int_q <= CLEAN_INTERVAL_RST;
      max_age_q   <= MAX_AGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CLEAN_INTERVAL: clean_int_q <= cfg_wdata_i;
        CFG_MAX_AGE:        max_age_q   <= cfg_wdata_i;
        default:            clean_int_q <= clean_int_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    sweep_q     <= sweep_d;
    rv_idx_q    <= rv_idx_d;
    acc_found_q <= acc_found_d;
    acc_seq_q   <= acc_seq_d;
    acc_bytes_q <= acc_bytes_d;
    acc_idx_q   <= acc_idx_d;
    acc_sum_q   <= acc_sum_d;
    low_idx_q   <= low_idx_d;
    res_found_q <= res_found_d;
    res_seq_q   <= res_seq_d;
    res_bytes_q <= res_bytes_d;
    res_cnt_q   <= res_cnt_d;
    res_over_q  <= res_over_d;
    out_q       <= out_d;
  end

  // checks
  `RTPB_ASSERT(a_accept_starts_read, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ), "accept did not start a read")
  `RTPB_ASSERT(a_scan_write_on_sweep, clk_i, rst_ni,
    (state_q == ST_SCAN && mem_we) |-> sweep_q, "table written in a scan without sweep")
  `RTPB_ASSERT(a_total_needs_lowest, clk_i, rst_ni,
    (pend_sum_q != '0) |-> low_valid_q, "pending bytes without a lowest record")
  `RTPB_ASSERT_NEVER(a_no_result_overrun, clk_i, rst_ni,
    (state_q == ST_FINISH) && (state_d == ST_IDLE) && out_valid_q && !out_ready_i,
    "result loaded over one not yet taken")

endmodule
